// ----- design/llt_pkg.sv -----
// Shared kinds, error codes, command decode and handshake structs for the tokenizer.
package llt_pkg;

   // Record kinds on the result channel
   localparam logic [3:0] KIND_PTR_UP  = 4'd0;
   localparam logic [3:0] KIND_PTR_DN  = 4'd1;
   localparam logic [3:0] KIND_INC     = 4'd2;
   localparam logic [3:0] KIND_DEC     = 4'd3;
   localparam logic [3:0] KIND_WRITE   = 4'd4;
   localparam logic [3:0] KIND_READ    = 4'd5;
   localparam logic [3:0] KIND_OPEN    = 4'd6;
   localparam logic [3:0] KIND_CLOSE   = 4'd7;
   localparam logic [3:0] KIND_END     = 4'd8;

   // Command codes as held internally (low three bits of the kind)
   localparam logic [2:0] CMD_PTR_UP   = 3'd0;
   localparam logic [2:0] CMD_PTR_DN   = 3'd1;
   localparam logic [2:0] CMD_INC      = 3'd2;
   localparam logic [2:0] CMD_DEC      = 3'd3;
   localparam logic [2:0] CMD_WRITE    = 3'd4;
   localparam logic [2:0] CMD_READ     = 3'd5;
   localparam logic [2:0] CMD_OPEN     = 3'd6;
   localparam logic [2:0] CMD_CLOSE    = 3'd7;

   // End record error codes
   localparam logic [2:0] ERR_OK          = 3'd0;
   localparam logic [2:0] ERR_STRAY_CLOSE = 3'd1;
   localparam logic [2:0] ERR_UNCLOSED    = 3'd2;
   localparam logic [2:0] ERR_TOO_DEEP    = 3'd3;
   localparam logic [2:0] ERR_TOO_LONG    = 3'd4;

   // Source characters
   localparam logic [7:0] CHAR_PTR_UP  = 8'h3E; // >
   localparam logic [7:0] CHAR_PTR_DN  = 8'h3C; // <
   localparam logic [7:0] CHAR_INC     = 8'h2B; // +
   localparam logic [7:0] CHAR_DEC     = 8'h2D; // -
   localparam logic [7:0] CHAR_WRITE   = 8'h2E; // .
   localparam logic [7:0] CHAR_READ    = 8'h2C; // ,
   localparam logic [7:0] CHAR_OPEN    = 8'h5B; // [
   localparam logic [7:0] CHAR_CLOSE   = 8'h5D; // ]

   // One item gives at most three records: flushed run, bracket or run, end
   localparam int NUM_SLOTS = 3;
   localparam int SLOT_BITS = 2;

   typedef struct packed {
      logic       is_cmd;
      logic [2:0] cmd;
   } cmd_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] kind;
      logic [2:0] err;
      logic       use_match;
   } rec_ctl_type;

   typedef struct packed {
      logic [SLOT_BITS-1:0] remain;
      logic                 out_load;
      logic                 can_load;
   } emit_stat_type;

   function automatic cmd_type decode_char(input logic [7:0] code);
      cmd_type res;
      res.is_cmd = 1'b1;
      res.cmd    = CMD_PTR_UP;
      case (code)
         CHAR_PTR_UP: res.cmd = CMD_PTR_UP;
         CHAR_PTR_DN: res.cmd = CMD_PTR_DN;
         CHAR_INC:    res.cmd = CMD_INC;
         CHAR_DEC:    res.cmd = CMD_DEC;
         CHAR_WRITE:  res.cmd = CMD_WRITE;
         CHAR_READ:   res.cmd = CMD_READ;
         CHAR_OPEN:   res.cmd = CMD_OPEN;
         CHAR_CLOSE:  res.cmd = CMD_CLOSE;
         default:     res.is_cmd = 1'b0;
      endcase
      return res;
   endfunction

endpackage

// ----- design/llt_stack.sv -----
// Open-bracket index memory: one push port, one registered pop read port.
module llt_stack #(
   parameter int STACK_DEPTH = 64,
   parameter int INDEX_BITS  = 16,
   parameter int ADDR_BITS   = 6
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_BITS-1:0]  wr_addr,
   input  logic [INDEX_BITS-1:0] wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_BITS-1:0]  rd_addr,
   output logic [INDEX_BITS-1:0] rd_data
);

   logic [INDEX_BITS-1:0] mem [STACK_DEPTH];
   logic [INDEX_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/llt_parse.sv -----
// Tokenizer state and single-pass step: merge runs, pair brackets, build records.
module llt_parse #(
   parameter int STACK_DEPTH = 64,
   parameter int INDEX_BITS  = 16,
   parameter int COUNT_BITS  = 16,
   parameter int ADDR_BITS   = 6,
   parameter int FILL_BITS   = 7
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              accept,
   input  logic                                              has_char,
   input  logic [7:0]                                        char_code,
   input  logic                                              last,
   output llt_pkg::rec_ctl_type [llt_pkg::NUM_SLOTS-1:0]     rec_ctl,
   output logic [llt_pkg::NUM_SLOTS-1:0][INDEX_BITS-1:0]     rec_index,
   output logic [llt_pkg::NUM_SLOTS-1:0][COUNT_BITS-1:0]     rec_times,
   output logic                                              wr_en,
   output logic [ADDR_BITS-1:0]                              wr_addr,
   output logic [INDEX_BITS-1:0]                             wr_data,
   output logic                                              rd_en,
   output logic [ADDR_BITS-1:0]                              rd_addr
);

   localparam logic [INDEX_BITS:0] INDEX_LIMIT = {1'b0, {INDEX_BITS{1'b1}}};

   logic                  held_valid_ff, held_valid_in;
   logic [2:0]            held_kind_ff,  held_kind_in;
   logic [COUNT_BITS-1:0] held_count_ff, held_count_in;
   logic [INDEX_BITS-1:0] next_pos_ff,   next_pos_in;
   logic [FILL_BITS-1:0]  fill_ff,       fill_in;
   logic                  failed_ff,     failed_in;

   llt_pkg::cmd_type      cmd;
   logic                  h_v;
   logic [2:0]            h_k;
   logic [COUNT_BITS-1:0] h_c;
   logic [INDEX_BITS-1:0] pos;
   logic [FILL_BITS-1:0]  fill;
   logic [FILL_BITS-1:0]  fill_dec;
   logic [INDEX_BITS:0]   need;
   logic                  err_v;
   logic [2:0]            err_c;
   logic                  do_clear;
   logic                  is_bracket;

   assign fill_dec = fill_ff - 1'b1;

   always_comb begin
      cmd        = llt_pkg::decode_char(char_code);
      is_bracket = cmd.cmd[2] & cmd.cmd[1];
      rec_ctl    = '0;
      rec_index  = '0;
      rec_times  = '0;
      wr_en      = 1'b0;
      wr_addr    = fill_ff[ADDR_BITS-1:0];
      wr_data    = '0;
      rd_en      = 1'b0;
      rd_addr    = fill_dec[ADDR_BITS-1:0];
      h_v        = held_valid_ff;
      h_k        = held_kind_ff;
      h_c        = held_count_ff;
      pos        = next_pos_ff;
      fill       = fill_ff;
      need       = (INDEX_BITS+1)'(held_valid_ff) + (INDEX_BITS+1)'(is_bracket);
      err_v      = 1'b0;
      err_c      = llt_pkg::ERR_OK;
      do_clear   = 1'b0;

      held_valid_in = held_valid_ff;
      held_kind_in  = held_kind_ff;
      held_count_in = held_count_ff;
      next_pos_in   = next_pos_ff;
      fill_in       = fill_ff;
      failed_in     = failed_ff;

      if (accept) begin
         if (failed_ff) begin
            // drop everything until the last byte
            do_clear = last;
         end else begin
            if (has_char && cmd.is_cmd) begin
               if (!is_bracket && h_v && h_k == cmd.cmd && !(&h_c)) begin
                  h_c = h_c + 1'b1;
               end else if (cmd.cmd == llt_pkg::CMD_CLOSE && fill == '0) begin
                  err_v = 1'b1;
                  err_c = llt_pkg::ERR_STRAY_CLOSE;
               end else if (cmd.cmd == llt_pkg::CMD_OPEN &&
                            fill == FILL_BITS'(STACK_DEPTH)) begin
                  err_v = 1'b1;
                  err_c = llt_pkg::ERR_TOO_DEEP;
               end else if ({1'b0, pos} + need > INDEX_LIMIT) begin
                  err_v = 1'b1;
                  err_c = llt_pkg::ERR_TOO_LONG;
               end else begin
                  if (h_v) begin
                     rec_ctl[0].valid = 1'b1;
                     rec_ctl[0].kind  = {1'b0, h_k};
                     rec_index[0]     = pos;
                     rec_times[0]     = h_c;
                     pos              = pos + 1'b1;
                     h_v              = 1'b0;
                     h_k              = llt_pkg::CMD_PTR_UP;
                     h_c              = '0;
                  end
                  if (cmd.cmd == llt_pkg::CMD_OPEN) begin
                     wr_en            = 1'b1;
                     wr_data          = pos;
                     rec_ctl[1].valid = 1'b1;
                     rec_ctl[1].kind  = llt_pkg::KIND_OPEN;
                     rec_index[1]     = pos;
                     rec_times[1]     = COUNT_BITS'(1);
                     fill             = fill + 1'b1;
                     pos              = pos + 1'b1;
                  end else if (cmd.cmd == llt_pkg::CMD_CLOSE) begin
                     rd_en                = 1'b1;
                     rec_ctl[1].valid     = 1'b1;
                     rec_ctl[1].kind      = llt_pkg::KIND_CLOSE;
                     rec_ctl[1].use_match = 1'b1;
                     rec_index[1]         = pos;
                     rec_times[1]         = COUNT_BITS'(1);
                     fill                 = fill - 1'b1;
                     pos                  = pos + 1'b1;
                  end else begin
                     h_v = 1'b1;
                     h_k = cmd.cmd;
                     h_c = COUNT_BITS'(1);
                  end
               end
            end

            if (!err_v && last) begin
               if (h_v) begin
                  if (pos == INDEX_LIMIT[INDEX_BITS-1:0]) begin
                     err_v = 1'b1;
                     err_c = llt_pkg::ERR_TOO_LONG;
                  end else begin
                     // a bracket never leaves a run held, so the middle slot is free
                     rec_ctl[1].valid = 1'b1;
                     rec_ctl[1].kind  = {1'b0, h_k};
                     rec_index[1]     = pos;
                     rec_times[1]     = h_c;
                     pos              = pos + 1'b1;
                  end
               end
               if (!err_v) begin
                  rec_ctl[2].valid = 1'b1;
                  rec_ctl[2].kind  = llt_pkg::KIND_END;
                  rec_ctl[2].err   = (fill != '0) ? llt_pkg::ERR_UNCLOSED : llt_pkg::ERR_OK;
                  rec_index[2]     = pos;
               end
               do_clear = 1'b1;
            end

            if (err_v) begin
               // held run is discarded on error
               rec_ctl[2].valid = 1'b1;
               rec_ctl[2].kind  = llt_pkg::KIND_END;
               rec_ctl[2].err   = err_c;
               rec_index[2]     = pos;
               do_clear         = last;
               failed_in        = !last;
               held_valid_in    = 1'b0;
               held_kind_in     = llt_pkg::CMD_PTR_UP;
               held_count_in    = '0;
            end else if (!do_clear) begin
               held_valid_in = h_v;
               held_kind_in  = h_k;
               held_count_in = h_c;
               next_pos_in   = pos;
               fill_in       = fill;
            end
         end

         if (do_clear) begin
            held_valid_in = 1'b0;
            held_kind_in  = llt_pkg::CMD_PTR_UP;
            held_count_in = '0;
            next_pos_in   = '0;
            fill_in       = '0;
            failed_in     = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         held_kind_ff  <= llt_pkg::CMD_PTR_UP;
         held_count_ff <= '0;
         next_pos_ff   <= '0;
         fill_ff       <= '0;
         failed_ff     <= 1'b0;
      end else begin
         held_valid_ff <= held_valid_in;
         held_kind_ff  <= held_kind_in;
         held_count_ff <= held_count_in;
         next_pos_ff   <= next_pos_in;
         fill_ff       <= fill_in;
         failed_ff     <= failed_in;
      end
   end

endmodule

// ----- design/llt_emit.sv -----
// Pending record slots of one item and the result output register.
module llt_emit #(
   parameter int INDEX_BITS = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          load,
   input  llt_pkg::rec_ctl_type [llt_pkg::NUM_SLOTS-1:0] rec_ctl,
   input  logic [llt_pkg::NUM_SLOTS-1:0][INDEX_BITS-1:0] rec_index,
   input  logic [llt_pkg::NUM_SLOTS-1:0][COUNT_BITS-1:0] rec_times,
   input  logic [INDEX_BITS-1:0]                         match_data,
   input  logic                                          rsp_ready,
   output logic                                          rsp_valid,
   output logic [3:0]                                    rsp_kind,
   output logic [INDEX_BITS-1:0]                         rsp_index,
   output logic [COUNT_BITS-1:0]                         rsp_times,
   output logic [INDEX_BITS-1:0]                         rsp_match_index,
   output logic [2:0]                                    rsp_error_code,
   output logic                                          rsp_final_res,
   output llt_pkg::emit_stat_type                        stat
);

   llt_pkg::rec_ctl_type [llt_pkg::NUM_SLOTS-1:0]  pend_ctl_ff;
   logic [llt_pkg::NUM_SLOTS-1:0][INDEX_BITS-1:0]  pend_index_ff;
   logic [llt_pkg::NUM_SLOTS-1:0][COUNT_BITS-1:0]  pend_times_ff;

   logic                           rsp_valid_ff;
   logic [3:0]                     rsp_kind_ff;
   logic [INDEX_BITS-1:0]          rsp_index_ff;
   logic [COUNT_BITS-1:0]          rsp_times_ff;
   logic [INDEX_BITS-1:0]          rsp_match_ff;
   logic [2:0]                     rsp_err_ff;

   logic [llt_pkg::NUM_SLOTS-1:0]  pend_valid;
   logic                           head_v;
   logic [llt_pkg::SLOT_BITS-1:0]  head;
   logic                           out_load;

   always_comb begin
      head_v = 1'b0;
      head   = '0;
      for (int i = llt_pkg::NUM_SLOTS-1; i >= 0; i--) begin
         pend_valid[i] = pend_ctl_ff[i].valid;
         if (pend_ctl_ff[i].valid) begin
            head_v = 1'b1;
            head   = llt_pkg::SLOT_BITS'(i);
         end
      end
   end

   assign out_load       = head_v && (!rsp_valid_ff || rsp_ready);
   assign stat.out_load  = out_load;
   assign stat.remain    = llt_pkg::SLOT_BITS'($countones(pend_valid));
   assign stat.can_load  = (stat.remain == '0) ||
                           (stat.remain == llt_pkg::SLOT_BITS'(1) && out_load);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ctl_ff <= '0;
      end else if (load) begin
         pend_ctl_ff <= rec_ctl;
      end else if (out_load) begin
         pend_ctl_ff[head].valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pend_index_ff <= rec_index;
         pend_times_ff <= rec_times;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // advance the head record into the output register
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_kind_ff  <= pend_ctl_ff[head].kind;
         rsp_index_ff <= pend_index_ff[head];
         rsp_times_ff <= pend_times_ff[head];
         rsp_match_ff <= pend_ctl_ff[head].use_match ? match_data : '0;
         rsp_err_ff   <= pend_ctl_ff[head].err;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_index       = rsp_index_ff;
   assign rsp_times       = rsp_times_ff;
   assign rsp_match_index = rsp_match_ff;
   assign rsp_error_code  = rsp_err_ff;
   assign rsp_final_res   = (rsp_kind_ff == llt_pkg::KIND_END);

endmodule

// ----- design/loop_language_tokenizer_top.sv -----
// Streaming tokenizer for the eight-command loop language: top level.
//
// Source bytes enter on the req_ channel, one per transfer; req_last marks the
// final byte (req_has_char low with req_last high is a bare end marker).
// Compacted instruction records leave on the rsp_ channel, one per transfer:
// merged runs with a repeat count, loop open and close records (close carries
// its open's index), and an end record with an error code and rsp_final_res.
// A byte gives zero to three records. The first record of a byte appears on
// rsp_valid after passing the pending slots and the output register; further
// records follow one a cycle while rsp_ready is high. A new byte is taken every
// cycle while each byte gives at most one record and the receiver keeps up; more
// records keep req_ready low as the single result port drains the slots.
// When rsp_ready is low the output register holds its record, the pending slots
// fill, and req_ready drops until the last pending record moves out.
// Reset clears run, position, stack fill and error state and empties the
// output side; bracket memory contents are not cleared and need not be.
module loop_language_tokenizer_top #(
   parameter int STACK_DEPTH = 64,
   parameter int INDEX_BITS  = 16,
   parameter int COUNT_BITS  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_has_char,
   input  logic [7:0]            req_char_code,
   input  logic                  req_last,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [3:0]            rsp_kind,
   output logic [INDEX_BITS-1:0] rsp_index,
   output logic [COUNT_BITS-1:0] rsp_times,
   output logic [INDEX_BITS-1:0] rsp_match_index,
   output logic [2:0]            rsp_error_code,
   output logic                  rsp_final_res
);

   localparam int ADDR_BITS = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int FILL_BITS = $clog2(STACK_DEPTH + 1);

   llt_pkg::rec_ctl_type [llt_pkg::NUM_SLOTS-1:0] rec_ctl;
   logic [llt_pkg::NUM_SLOTS-1:0][INDEX_BITS-1:0] rec_index;
   logic [llt_pkg::NUM_SLOTS-1:0][COUNT_BITS-1:0] rec_times;
   llt_pkg::emit_stat_type                        stat;

   logic                  accept;
   logic                  wr_en;
   logic [ADDR_BITS-1:0]  wr_addr;
   logic [INDEX_BITS-1:0] wr_data;
   logic                  rd_en;
   logic [ADDR_BITS-1:0]  rd_addr;
   logic [INDEX_BITS-1:0] rd_data;

   assign req_ready = stat.can_load;
   assign accept    = req_valid && req_ready;

   llt_parse #(
      .STACK_DEPTH (STACK_DEPTH),
      .INDEX_BITS  (INDEX_BITS),
      .COUNT_BITS  (COUNT_BITS),
      .ADDR_BITS   (ADDR_BITS),
      .FILL_BITS   (FILL_BITS)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .has_char  (req_has_char),
      .char_code (req_char_code),
      .last      (req_last),
      .rec_ctl   (rec_ctl),
      .rec_index (rec_index),
      .rec_times (rec_times),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr)
   );

   llt_stack #(
      .STACK_DEPTH (STACK_DEPTH),
      .INDEX_BITS  (INDEX_BITS),
      .ADDR_BITS   (ADDR_BITS)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   llt_emit #(
      .INDEX_BITS (INDEX_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_emit (
      .clock           (clock),
      .reset           (reset),
      .load            (accept),
      .rec_ctl         (rec_ctl),
      .rec_index       (rec_index),
      .rec_times       (rec_times),
      .match_data      (rd_data),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_kind        (rsp_kind),
      .rsp_index       (rsp_index),
      .rsp_times       (rsp_times),
      .rsp_match_index (rsp_match_index),
      .rsp_error_code  (rsp_error_code),
      .rsp_final_res   (rsp_final_res),
      .stat            (stat)
   );

   a_end_record_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_final_res |-> rsp_times == '0 && rsp_match_index == '0)
      else $error("end record carries a count or match index");

   a_error_only_on_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code != llt_pkg::ERR_OK |-> rsp_final_res)
      else $error("error code on a non-end record");

   a_close_points_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == llt_pkg::KIND_CLOSE |-> rsp_match_index < rsp_index)
      else $error("loop close matched to a later index");

   a_no_accept_while_backed_up: assert property (@(posedge clock) disable iff (reset)
      stat.remain > llt_pkg::SLOT_BITS'(1) |-> !req_ready)
      else $error("input taken while several records still pending");

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the loop language tokenizer: record predictor, drivers, monitors.
`timescale 1ns / 100ps

module testbench;

   localparam int STACK_DEPTH    = 64;
   localparam int INDEX_BITS     = 16;
   localparam int COUNT_BITS     = 16;
   localparam int INDEX_ALL_ONES = (1 << INDEX_BITS) - 1;
   localparam int COUNT_MAX      = (1 << COUNT_BITS) - 1;
   localparam int RANDOM_ITEMS   = 250;
   localparam int LIMIT_CYCLES   = 3000000;
   localparam int REPORT_LIMIT   = 10;

   typedef struct packed {
      logic [3:0]            kind;
      logic [INDEX_BITS-1:0] index;
      logic [COUNT_BITS-1:0] times;
      logic [INDEX_BITS-1:0] match_idx;
      logic [2:0]            err;
      logic                  is_end;
   } tok_rec_type;

   class token_ledger_type;
      tok_rec_type           pending_records[$];
      int                    bad_records;
      logic [2:0]            run_cmd;
      logic [COUNT_BITS-1:0] run_count;
      bit                    run_live;
      int unsigned           write_pos;
      logic [INDEX_BITS-1:0] open_positions[STACK_DEPTH];
      int                    depth;
      bit                    halted;

      function new();
         bad_records = 0;
         clear_state();
      endfunction

      function void clear_state();
         run_cmd   = llt_pkg::CMD_PTR_UP;
         run_count = '0;
         run_live  = 1'b0;
         write_pos = 0;
         depth     = 0;
         halted    = 1'b0;
      endfunction

      function void push_record(logic [3:0] kind, int unsigned idx, int unsigned times,
                                logic [INDEX_BITS-1:0] mi, logic [2:0] err, bit fin);
         tok_rec_type r;
         r.kind      = kind;
         r.index     = idx[INDEX_BITS-1:0];
         r.times     = times[COUNT_BITS-1:0];
         r.match_idx = mi;
         r.err       = err;
         r.is_end    = fin;
         pending_records.push_back(r);
      endfunction

      function void drop_run();
         run_live  = 1'b0;
         run_count = '0;
         run_cmd   = llt_pkg::CMD_PTR_UP;
      endfunction

      // Error: end record at once, held run discarded
      function void abort(logic [2:0] code, bit fin_byte);
         push_record(llt_pkg::KIND_END, write_pos, 0, '0, code, 1'b1);
         if (fin_byte) begin
            clear_state();
         end else begin
            halted = 1'b1;
            drop_run();
         end
      endfunction

      function void flush_run();
         push_record({1'b0, run_cmd}, write_pos, 32'(run_count), '0, llt_pkg::ERR_OK, 1'b0);
         write_pos++;
         drop_run();
      endfunction

      function bit decode_cmd(input logic [7:0] code, output logic [2:0] cmd);
         cmd = llt_pkg::CMD_PTR_UP;
         case (code)
            llt_pkg::CHAR_PTR_UP: cmd = llt_pkg::CMD_PTR_UP;
            llt_pkg::CHAR_PTR_DN: cmd = llt_pkg::CMD_PTR_DN;
            llt_pkg::CHAR_INC:    cmd = llt_pkg::CMD_INC;
            llt_pkg::CHAR_DEC:    cmd = llt_pkg::CMD_DEC;
            llt_pkg::CHAR_WRITE:  cmd = llt_pkg::CMD_WRITE;
            llt_pkg::CHAR_READ:   cmd = llt_pkg::CMD_READ;
            llt_pkg::CHAR_OPEN:   cmd = llt_pkg::CMD_OPEN;
            llt_pkg::CHAR_CLOSE:  cmd = llt_pkg::CMD_CLOSE;
            default:              return 1'b0;
         endcase
         return 1'b1;
      endfunction

      function void take_byte(bit has, logic [7:0] code, bit fin_byte);
         logic [2:0]  cmd;
         bit          is_cmd;
         bit          is_loop;
         int unsigned need;
         if (halted) begin
            if (fin_byte) clear_state();
            return;
         end
         is_cmd  = decode_cmd(code, cmd) && has;
         is_loop = (cmd == llt_pkg::CMD_OPEN) || (cmd == llt_pkg::CMD_CLOSE);
         if (is_cmd) begin
            if (!is_loop && run_live && run_cmd == cmd && run_count < COUNT_MAX) begin
               run_count++;
            end else begin
               need = (run_live ? 1 : 0) + (is_loop ? 1 : 0);
               if (cmd == llt_pkg::CMD_CLOSE && depth == 0) begin
                  abort(llt_pkg::ERR_STRAY_CLOSE, fin_byte);
                  return;
               end
               if (cmd == llt_pkg::CMD_OPEN && depth >= STACK_DEPTH) begin
                  abort(llt_pkg::ERR_TOO_DEEP, fin_byte);
                  return;
               end
               if (write_pos + need > INDEX_ALL_ONES) begin
                  abort(llt_pkg::ERR_TOO_LONG, fin_byte);
                  return;
               end
               if (run_live) flush_run();
               if (cmd == llt_pkg::CMD_OPEN) begin
                  open_positions[depth] = write_pos[INDEX_BITS-1:0];
                  depth++;
                  push_record(llt_pkg::KIND_OPEN, write_pos, 1, '0, llt_pkg::ERR_OK, 1'b0);
                  write_pos++;
               end else if (cmd == llt_pkg::CMD_CLOSE) begin
                  depth--;
                  push_record(llt_pkg::KIND_CLOSE, write_pos, 1, open_positions[depth],
                              llt_pkg::ERR_OK, 1'b0);
                  write_pos++;
               end else begin
                  run_cmd   = cmd;
                  run_count = COUNT_BITS'(1);
                  run_live  = 1'b1;
               end
            end
         end
         if (fin_byte) begin
            if (run_live) begin
               if (write_pos + 1 > INDEX_ALL_ONES) begin
                  abort(llt_pkg::ERR_TOO_LONG, 1'b1);
                  return;
               end
               flush_run();
            end
            push_record(llt_pkg::KIND_END, write_pos, 0, '0,
                        (depth > 0) ? llt_pkg::ERR_UNCLOSED : llt_pkg::ERR_OK, 1'b1);
            clear_state();
         end
      endfunction

      function void match_record(tok_rec_type got);
         tok_rec_type want;
         if (pending_records.size() == 0) begin
            bad_records++;
            if (bad_records <= REPORT_LIMIT)
               $display("unexpected record: kind %0d index %0d times %0d match %0d err %0d end %0d",
                        got.kind, got.index, got.times, got.match_idx, got.err, got.is_end);
            return;
         end
         want = pending_records.pop_front();
         if (got.kind !== want.kind || got.index !== want.index || got.times !== want.times ||
             got.match_idx !== want.match_idx || got.err !== want.err ||
             got.is_end !== want.is_end) begin
            bad_records++;
            if (bad_records <= REPORT_LIMIT) begin
               $display("record mismatch at %0t", $realtime);
               $display("  exp: kind %0d index %0d times %0d match %0d err %0d end %0d",
                        want.kind, want.index, want.times, want.match_idx, want.err,
                        want.is_end);
               $display("  got: kind %0d index %0d times %0d match %0d err %0d end %0d",
                        got.kind, got.index, got.times, got.match_idx, got.err, got.is_end);
            end
         end
      endfunction

      function void wrap_up();
         if (pending_records.size() != 0) begin
            bad_records += pending_records.size();
            $display("%0d expected records never arrived", pending_records.size());
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_has_char;
   logic [7:0]            req_char_code;
   logic                  req_last;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [3:0]            rsp_kind;
   logic [INDEX_BITS-1:0] rsp_index;
   logic [COUNT_BITS-1:0] rsp_times;
   logic [INDEX_BITS-1:0] rsp_match_index;
   logic [2:0]            rsp_error_code;
   logic                  rsp_final_res;

   token_ledger_type ledger;
   tok_rec_type      seen_rec;
   bit               tx_idling;
   bit               rx_idling;
   bit               long_hold_req;
   int               items_sent;
   int               watch_cycles;

   loop_language_tokenizer_top #(
      .STACK_DEPTH(STACK_DEPTH),
      .INDEX_BITS (INDEX_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_has_char   (req_has_char),
      .req_char_code  (req_char_code),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_index      (rsp_index),
      .rsp_times      (rsp_times),
      .rsp_match_index(rsp_match_index),
      .rsp_error_code (rsp_error_code),
      .rsp_final_res  (rsp_final_res)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog
   initial begin
      for (watch_cycles = 0; watch_cycles < LIMIT_CYCLES; watch_cycles++) @(posedge clock);
      $display("testbench NOT OK");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         ledger.take_byte(req_has_char, req_char_code, req_last);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen_rec.kind      = rsp_kind;
         seen_rec.index     = rsp_index;
         seen_rec.times     = rsp_times;
         seen_rec.match_idx = rsp_match_index;
         seen_rec.err       = rsp_error_code;
         seen_rec.is_end    = rsp_final_res;
         ledger.match_record(seen_rec);
      end
   end

   // Receiver: random stall bursts, plus one long hold on request
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall_left    = 299;
            rsp_ready    <= 1'b0;
         end else if (rx_idling && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 19) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after the transfer
   task automatic send_byte(input bit has, input logic [7:0] code, input bit fin);
      if (tx_idling && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_has_char  <= has;
      req_char_code <= code;
      req_last      <= fin;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s, input bit ends_program);
      for (int i = 0; i < s.len(); i++)
         send_byte(1'b1, s[i], ends_program && (i == s.len() - 1));
   endtask

   task automatic wait_for_drain();
      while (ledger.pending_records.size() != 0) @(negedge clock);
   endtask

   function automatic logic [7:0] plain_char();
      case ($urandom_range(0, 5))
         0:       return llt_pkg::CHAR_PTR_UP;
         1:       return llt_pkg::CHAR_PTR_DN;
         2:       return llt_pkg::CHAR_INC;
         3:       return llt_pkg::CHAR_DEC;
         4:       return llt_pkg::CHAR_WRITE;
         default: return llt_pkg::CHAR_READ;
      endcase
   endfunction

   // Mostly balanced programs with runs; some noise, bare markers and strays
   task automatic random_program();
      int         body_len;
      int         depth;
      int         pick;
      bit         has;
      logic [7:0] code;
      logic [7:0] prev;
      body_len = $urandom_range(0, 22);
      depth    = 0;
      prev     = plain_char();
      for (int i = 0; i < body_len; i++) begin
         has  = 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            code = 8'($urandom_range(0, 255));
         end else if (pick < 13) begin
            has  = 1'b0;
            code = 8'($urandom_range(0, 255));
         end else if (pick < 38) begin
            code = prev;
         end else if (pick < 52) begin
            code = llt_pkg::CHAR_OPEN;
            depth++;
         end else if (pick < 68) begin
            if (depth > 0 || $urandom_range(0, 9) == 0) begin
               code = llt_pkg::CHAR_CLOSE;
               if (depth > 0) depth--;
            end else begin
               code = prev;
            end
         end else begin
            code = plain_char();
            prev = code;
         end
         send_byte(has, code, 1'b0);
      end
      if ($urandom_range(0, 3) != 0)
         repeat (depth) send_byte(1'b1, llt_pkg::CHAR_CLOSE, 1'b0);
      if ($urandom_range(0, 2) == 0)
         send_byte(1'b0, 8'($urandom_range(0, 255)), 1'b1);
      else
         send_byte(1'b1, ($urandom_range(0, 1) == 0) ? prev : plain_char(), 1'b1);
   endtask

   initial begin
      int programs;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_has_char  = 1'b0;
      req_char_code = 8'h00;
      req_last      = 1'b0;
      tx_idling     = 1'b0;
      rx_idling     = 1'b0;
      long_hold_req = 1'b0;
      items_sent    = 0;
      ledger        = new();
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty program, every command, noise extremes, errors
      send_byte(1'b0, 8'hFF, 1'b0);
      send_byte(1'b0, 8'h00, 1'b1);
      send_text("++>[<-].,", 1'b0);
      send_byte(1'b1, 8'hFF, 1'b0);
      send_byte(1'b1, 8'h00, 1'b1);
      send_text("]+-", 1'b1);
      send_text("[[", 1'b1);
      send_text("-", 1'b0);
      send_byte(1'b0, llt_pkg::CHAR_INC, 1'b1);

      // Random programs with idling on both sides
      programs = 0;
      while (items_sent < RANDOM_ITEMS) begin
         tx_idling = ($urandom_range(0, 3) != 0);
         rx_idling = ($urandom_range(0, 3) != 0);
         if (programs == 2) long_hold_req = 1'b1;
         if (programs == 4) begin
            req_valid <= 1'b0;
            @(negedge clock);
            wait_for_drain();
         end
         random_program();
         programs++;
      end

      // No idling from here: stack limits
      tx_idling = 1'b0;
      rx_idling = 1'b0;
      repeat (STACK_DEPTH) send_byte(1'b1, llt_pkg::CHAR_OPEN, 1'b0);
      repeat (STACK_DEPTH - 1) send_byte(1'b1, llt_pkg::CHAR_CLOSE, 1'b0);
      send_byte(1'b1, llt_pkg::CHAR_CLOSE, 1'b1);
      repeat (STACK_DEPTH + 1) send_byte(1'b1, llt_pkg::CHAR_OPEN, 1'b0);
      send_byte(1'b0, 8'h00, 1'b1);

      req_valid <= 1'b0;
      wait_for_drain();
      repeat (20) @(posedge clock);
      ledger.wrap_up();
      if (ledger.bad_records == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule

// ----- sim.f -----
design/llt_pkg.sv
design/llt_stack.sv
design/llt_parse.sv
design/llt_emit.sv
design/loop_language_tokenizer_top.sv
sim/testbench.sv
